>>> design/hnorm_pkg.sv
// Shared constants, types and the byte class function of the text normalizer.
package hnorm_pkg;

    localparam int unsigned RES_MAX = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_C2    = 8'hc2;
    localparam logic [7:0] CH_E2    = 8'he2;
    localparam logic [7:0] E2_LO    = 8'h80;
    localparam logic [7:0] E2_HI    = 8'had;

    localparam logic [7:0][31:0] KEEP_MAP = {
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        32'h07fffffe, 32'h87fffffe, 32'h03ff2000, 32'h00000000
    };

    // Results caused by one input item, sent out one per cycle while the receiver is ready.
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    fin;
        logic                    bval;
    } grp_t;

    function automatic logic is_kept(input logic [7:0] c);
        logic [31:0] row;
        row = KEEP_MAP[c[7:5]];
        return row[c[4:0]];
    endfunction

endpackage

>>> design/hnorm_if.sv
// Valid/ready channel interfaces for input items and result items.
interface hnorm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface hnorm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       chunk_done;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_valid,
                    output chunk_done, output run_last, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input chunk_done, input run_last, output ready);
endinterface

>>> design/html_text_normalizer.sv
// Top level of the text normalizer: input register, byte state machine, result serializer.
//
// ingress carries one raw byte per item (in_byte) with chunk_end marking the
// last byte of a chunk. egress carries normalized results: out_byte,
// byte_valid (0 only on a bare end marker), chunk_done on the chunk's final
// result and run_last on the last result caused by one input item.
// An input item causes zero to three results; a chunk_end item always
// causes at least one.
// An accepted item is held in the input register until the serializer is free;
// its result group is then loaded into the group register, from which its
// results appear on egress.
// Throughput: one item per cycle while each item causes at most one result
// and egress.ready is high. An item causing two or three results holds the
// serializer until its last result is taken, and ingress stalls behind it.
// Items causing no result do not hold the serializer.
// Reset clears the normalizer state and empties both registers; no result
// is pending afterwards. While egress.ready is low the current result
// holds, and the input register takes one more item before ingress.ready
// drops.
module html_text_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    hnorm_in_if.sink    ingress,
    hnorm_out_if.source egress
);

    logic            in_v_reg;
    logic [7:0]      in_byte_reg;
    logic            in_end_reg;
    logic            free;
    logic            adv;
    hnorm_pkg::grp_t grp;

    assign adv           = in_v_reg && free;
    assign ingress.ready = !in_v_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (ingress.ready)
        begin
            in_v_reg <= ingress.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ingress.ready && ingress.valid)
        begin
            in_byte_reg <= ingress.in_byte;
            in_end_reg  <= ingress.chunk_end;
        end
    end

    hnorm_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_byte   (in_byte_reg),
        .chunk_end (in_end_reg),
        .grp       (grp)
    );

    hnorm_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv),
        .grp    (grp),
        .free   (free),
        .egress (egress)
    );

endmodule

>>> design/hnorm_step.sv
// Per-byte normalizer state machine: computes the result group of one item.
module hnorm_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [7:0]           in_byte,
    input  logic                 chunk_end,
    output hnorm_pkg::grp_t      grp
);

    typedef enum logic [2:0] {
        M_BEGIN,
        M_CHAR,
        M_AMP,
        M_C2,
        M_E2,
        M_E2_2
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  sp_reg, sp_next;
    logic  wa_reg, wa_next;
    logic  lws_reg, lws_next;

    always_comb
    begin
        logic [7:0] p0;
        logic [7:0] p1;
        logic [1:0] n0;
        logic       fin_add;
        p0        = hnorm_pkg::CH_SPACE;
        p1        = in_byte;
        n0        = 2'd0;
        mode_next = mode_reg;
        sp_next   = sp_reg;
        wa_next   = wa_reg;
        lws_next  = lws_reg;
        unique case (mode_reg)
            M_AMP:
            begin
                if (in_byte == hnorm_pkg::CH_SEMI)
                begin
                    if (!sp_reg)
                    begin
                        n0       = 2'd1;
                        sp_next  = 1'b1;
                        wa_next  = 1'b1;
                        lws_next = 1'b1;
                    end
                    mode_next = M_CHAR;
                end
            end
            M_C2, M_E2_2:
            begin
                mode_next = M_CHAR;
            end
            M_E2:
            begin
                if (in_byte >= hnorm_pkg::E2_LO && in_byte <= hnorm_pkg::E2_HI)
                begin
                    mode_next = M_E2_2;
                end
                else
                begin
                    p0        = hnorm_pkg::CH_E2;
                    n0        = 2'd2;
                    wa_next   = 1'b1;
                    lws_next  = (in_byte == hnorm_pkg::CH_SPACE);
                    mode_next = M_CHAR;
                end
            end
            default:
            begin
                if (in_byte == hnorm_pkg::CH_AMP)
                begin
                    mode_next = M_AMP;
                end
                else if (!hnorm_pkg::is_kept(in_byte))
                begin
                    if (mode_reg != M_BEGIN && !sp_reg)
                    begin
                        n0       = 2'd1;
                        sp_next  = 1'b1;
                        wa_next  = 1'b1;
                        lws_next = 1'b1;
                    end
                end
                else if (in_byte == hnorm_pkg::CH_C2)
                begin
                    mode_next = M_C2;
                end
                else if (in_byte == hnorm_pkg::CH_E2)
                begin
                    mode_next = M_E2;
                end
                else
                begin
                    p0        = in_byte;
                    n0        = 2'd1;
                    sp_next   = 1'b0;
                    wa_next   = 1'b1;
                    lws_next  = 1'b0;
                    mode_next = M_CHAR;
                end
            end
        endcase

        fin_add    = chunk_end && wa_next && !lws_next;
        grp.bytes  = {hnorm_pkg::CH_SPACE, p1, p0};
        grp.fin    = chunk_end;
        grp.bval   = 1'b1;
        grp.cnt    = n0 + {1'b0, fin_add};
        if (fin_add)
        begin
            case (n0)
                2'd0:    grp.bytes[0] = hnorm_pkg::CH_SPACE;
                2'd1:    grp.bytes[1] = hnorm_pkg::CH_SPACE;
                default: grp.bytes[2] = hnorm_pkg::CH_SPACE;
            endcase
        end
        if (chunk_end && n0 == 2'd0 && !fin_add)
        begin
            grp.cnt   = 2'd1;
            grp.bval  = 1'b0;
            grp.bytes = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_BEGIN;
            sp_reg   <= 1'b0;
            wa_reg   <= 1'b0;
            lws_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (chunk_end)
            begin
                mode_reg <= M_BEGIN;
                sp_reg   <= 1'b0;
                wa_reg   <= 1'b0;
                lws_reg  <= 1'b0;
            end
            else
            begin
                mode_reg <= mode_next;
                sp_reg   <= sp_next;
                wa_reg   <= wa_next;
                lws_reg  <= lws_next;
            end
        end
    end

endmodule

>>> design/hnorm_serial.sv
// Result group register; sends the group's results one item per cycle while egress.ready is high.
module hnorm_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hnorm_pkg::grp_t   grp,
    output logic              free,
    hnorm_out_if.source       egress
);

    hnorm_pkg::grp_t grp_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      idx_reg;
    logic            last;
    logic            take;
    logic [7:0]      cur_byte;

    assign last = (idx_reg == cnt_reg - 2'd1);
    assign take = egress.valid && egress.ready;
    assign free = (cnt_reg == 2'd0) || (take && last);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = grp_reg.bytes[0];
            2'd1:    cur_byte = grp_reg.bytes[1];
            default: cur_byte = grp_reg.bytes[2];
        endcase
    end

    assign egress.valid      = (cnt_reg != 2'd0);
    assign egress.out_byte   = grp_reg.bval ? cur_byte : 8'h00;
    assign egress.byte_valid = grp_reg.bval;
    assign egress.run_last   = last;
    assign egress.chunk_done = grp_reg.fin && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= grp.cnt;
            idx_reg <= 2'd0;
        end
        else if (take)
        begin
            if (last)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> idx_reg < cnt_reg)
        else $error("result index beyond group size");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("group loaded over unsent results");

    a_bare_result: assert property (@(posedge clk) disable iff (!rst_n)
        egress.valid && !egress.byte_valid |->
            egress.chunk_done && egress.run_last && egress.out_byte == 8'h00)
        else $error("bare result is not a lone chunk end");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take && last && !load |=> !egress.valid)
        else $error("result repeated after last of group");

endmodule

>>> dv/hnorm_checker.sv
// Normalizer checker: watches both channels, predicts each item's text bytes and compares them.
module hnorm_checker (
    input  logic clk,
    input  logic rst_n,
    hnorm_in_if  ingress,
    hnorm_out_if egress,
    output int   errors,
    output int   pending,
    output int   results_seen,
    output int   chunks_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_BEGIN,
        ST_TEXT,
        ST_ENTITY,
        ST_AFTER_C2,
        ST_AFTER_E2,
        ST_E2_SKIP
    } norm_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       chunk_done;
        logic       run_last;
    } text_res_t;

    norm_state_t st;
    logic        space_pend;
    logic        wrote_any;
    logic        last_space;
    logic [7:0]  wr_bytes [hnorm_pkg::RES_MAX];
    int          wr_cnt;
    text_res_t   text_q [$];

    function automatic logic keeps(input logic [7:0] c);
        return c >= 8'h80 || c == "-" || c == "_" || (c >= "0" && c <= "9")
            || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void clear_text_state();
        st = ST_BEGIN;
        space_pend = 1'b0;
        wrote_any = 1'b0;
        last_space = 1'b0;
    endfunction

    function automatic void write_byte(input logic [7:0] c);
        if (wr_cnt < hnorm_pkg::RES_MAX)
        begin
            wr_bytes[wr_cnt] = c;
            wr_cnt++;
        end
        wrote_any = 1'b1;
        last_space = (c == hnorm_pkg::CH_SPACE);
    endfunction

    function automatic void write_space_once();
        if (!space_pend)
        begin
            write_byte(hnorm_pkg::CH_SPACE);
            space_pend = 1'b1;
        end
    endfunction

    function automatic void predict_text(input logic [7:0] c, input logic fin);
        text_res_t r;
        wr_cnt = 0;
        case (st)
            ST_ENTITY:
            begin
                if (c == hnorm_pkg::CH_SEMI)
                begin
                    write_space_once();
                    st = ST_TEXT;
                end
            end
            ST_AFTER_C2, ST_E2_SKIP:
                st = ST_TEXT;
            ST_AFTER_E2:
            begin
                if (c >= hnorm_pkg::E2_LO && c <= hnorm_pkg::E2_HI)
                    st = ST_E2_SKIP;
                else
                begin
                    write_byte(hnorm_pkg::CH_E2);
                    write_byte(c);
                    st = ST_TEXT;
                end
            end
            default:
            begin
                if (c == hnorm_pkg::CH_AMP)
                    st = ST_ENTITY;
                else if (!keeps(c))
                begin
                    if (st != ST_BEGIN)
                        write_space_once();
                end
                else if (c == hnorm_pkg::CH_C2)
                    st = ST_AFTER_C2;
                else if (c == hnorm_pkg::CH_E2)
                    st = ST_AFTER_E2;
                else
                begin
                    write_byte(c);
                    space_pend = 1'b0;
                    st = ST_TEXT;
                end
            end
        endcase
        if (fin && wrote_any && !last_space)
            write_byte(hnorm_pkg::CH_SPACE);
        for (int k = 0; k < wr_cnt; k++)
        begin
            r.out_byte = wr_bytes[k];
            r.byte_valid = 1'b1;
            r.chunk_done = fin && (k == wr_cnt - 1);
            r.run_last = (k == wr_cnt - 1);
            text_q.push_back(r);
        end
        if (fin && wr_cnt == 0)
        begin
            r = '{out_byte: 8'h00, byte_valid: 1'b0, chunk_done: 1'b1, run_last: 1'b1};
            text_q.push_back(r);
        end
        if (fin)
            clear_text_state();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_res_t want;
        text_res_t got;
        if (!rst_n)
        begin
            clear_text_state();
            text_q.delete();
            errors = 0;
            pending = 0;
            results_seen = 0;
            chunks_seen = 0;
        end
        else
        begin
            if (ingress.valid && ingress.ready)
                predict_text(ingress.in_byte, ingress.chunk_end);
            if (egress.valid && egress.ready)
            begin
                got = '{egress.out_byte, egress.byte_valid, egress.chunk_done, egress.run_last};
                results_seen++;
                if (got.chunk_done)
                    chunks_seen++;
                if (text_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result byte=%h valid=%b done=%b last=%b",
                             $time, got.out_byte, got.byte_valid, got.chunk_done,
                             got.run_last);
                end
                else
                begin
                    want = text_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected byte=%h valid=%b done=%b last=%b",
                                 $time, want.out_byte, want.byte_valid, want.chunk_done,
                                 want.run_last);
                        $display("%0t:          actual   byte=%h valid=%b done=%b last=%b",
                                 $time, got.out_byte, got.byte_valid, got.chunk_done,
                                 got.run_last);
                    end
                end
            end
            pending = text_q.size();
        end
    end

endmodule

>>> dv/tb_top.sv
// Testbench top: clock, reset, byte stimulus, receiver stalls, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int WD_LIMIT     = 1000;
    localparam int PHASE_ITEMS  = 50;

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int pending;
    int results_seen;
    int chunks_seen;
    int items_sent;
    int src_idle_pct;
    int stall_pct;
    int hold_req;
    int idle_cycles;

    hnorm_in_if  in_ch ();
    hnorm_out_if out_ch ();

    html_text_normalizer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (in_ch),
        .egress  (out_ch)
    );

    hnorm_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .ingress      (in_ch),
        .egress       (out_ch),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .chunks_seen  (chunks_seen)
    );

    always #5 clk = ~clk;

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        int hold_ack;
        int hold_left;
        hold_ack = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic put_item(input logic [7:0] b, input logic fin);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.chunk_end <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            put_item(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic send_chunk(input logic [7:0] q[$]);
        foreach (q[i])
            put_item(q[i], i == q.size() - 1);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(4))
            0: return 8'("a" + $urandom_range(25));
            1: return 8'("A" + $urandom_range(25));
            2: return 8'("0" + $urandom_range(9));
            3: return "-";
            default: return "_";
        endcase
    endfunction

    // mostly well-formed text with entities and multibyte sequences, some noise
    task automatic build_chunk(ref logic [7:0] q[$]);
        int len;
        int pick;
        len = $urandom_range(1, 12);
        q.delete();
        while (q.size() < len)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                q.push_back(word_char());
            else if (pick < 45)
                q.push_back(($urandom_range(1) != 0) ? hnorm_pkg::CH_SPACE
                                                    : 8'($urandom_range(8'h2c)));
            else if (pick < 55)
            begin
                q.push_back(hnorm_pkg::CH_AMP);
                repeat ($urandom_range(4))
                    q.push_back(8'("a" + $urandom_range(25)));
                if ($urandom_range(3) != 0)
                    q.push_back(hnorm_pkg::CH_SEMI);
            end
            else if (pick < 63)
            begin
                q.push_back(hnorm_pkg::CH_C2);
                q.push_back(8'($urandom_range(255)));
            end
            else if (pick < 73)
            begin
                q.push_back(hnorm_pkg::CH_E2);
                q.push_back(8'($urandom_range(hnorm_pkg::E2_LO, hnorm_pkg::E2_HI)));
                q.push_back(8'($urandom_range(255)));
            end
            else if (pick < 80)
            begin
                q.push_back(hnorm_pkg::CH_E2);
                q.push_back(($urandom_range(1) != 0) ? 8'($urandom_range(8'h7f))
                                                    : 8'($urandom_range(8'hae, 8'hff)));
            end
            else
                q.push_back(8'($urandom_range(255)));
        end
        if (q.size() > 1 && $urandom_range(7) == 0)
            void'(q.pop_back());
    endtask

    task automatic random_phase(input int src_pct, input int sink_pct);
        logic [7:0] q[$];
        int start;
        src_idle_pct = src_pct;
        stall_pct = sink_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            build_chunk(q);
            send_chunk(q);
        end
        wait_drain();
    endtask

    initial
    begin
        logic [7:0] q[$];
        int start;
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.chunk_end <= 1'b0;
        items_sent = 0;
        src_idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        src_idle_pct = 20;
        stall_pct = 20;
        send_text(" &x;Z-_9", 1'b1);
        send_text("a", 1'b0);
        put_item(hnorm_pkg::CH_C2, 1'b0);
        put_item(8'ha0, 1'b0);
        send_text("b!?", 1'b0);
        put_item(hnorm_pkg::CH_E2, 1'b0);
        put_item(hnorm_pkg::E2_HI, 1'b0);
        put_item(8'h94, 1'b0);
        send_text("c", 1'b0);
        put_item(hnorm_pkg::CH_E2, 1'b0);
        put_item(hnorm_pkg::CH_SPACE, 1'b0);
        put_item(8'hff, 1'b1);
        put_item(8'h00, 1'b1);
        send_text("x", 1'b0);
        put_item(8'h00, 1'b1);
        put_item(hnorm_pkg::CH_E2, 1'b0);
        put_item(8'h41, 1'b1);
        wait_drain();

        random_phase(0, 0);

        // long receiver hold-off while the sender keeps pushing
        src_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        start = items_sent;
        while (items_sent - start < 30)
        begin
            build_chunk(q);
            send_chunk(q);
        end
        wait_drain();

        random_phase(57, 0);
        random_phase(0, 57);
        random_phase(10, 10);

        if (pending != 0)
            $display("%0t: %0d results never arrived", $time, pending);
        $display("Run: %0d items in %0d chunks, %0d results checked", items_sent,
                 chunks_seen, results_seen);
        $display("Idle mixes: none, sender, receiver, both; long hold-off and full drain");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> html_text_normalizer.f
design/hnorm_pkg.sv
design/hnorm_if.sv
design/hnorm_step.sv
design/hnorm_serial.sv
design/html_text_normalizer.sv
dv/hnorm_checker.sv
dv/tb_top.sv
